// ===== design/polyline_bezier_tessellator_defines.svh =====
// Assertion macros shared by the tessellator modules.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef POLYLINE_BEZIER_TESSELLATOR_DEFINES_SVH
`define POLYLINE_BEZIER_TESSELLATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PBT_ASSERT_ALWAYS(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("pbt: invariant violated");
`define PBT_ASSERT_IMPLIES(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pbt: implication violated");
`define PBT_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pbt: next-cycle check violated");
`else
`define PBT_ASSERT_ALWAYS(name, expr)
`define PBT_ASSERT_IMPLIES(name, ante, cons)
`define PBT_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== design/pbt_pkg.sv =====
`timescale 1ns / 1ps
package pbt_pkg;

	// coordinate width of the channels
	localparam int COORD_BITS = 16;
	// split points in half units
	localparam int HALF_BITS = COORD_BITS + 1;
	// curve control points with 16 fraction bits
	localparam int FRAC_BITS = 16;
	localparam int PT_BITS = COORD_BITS + FRAC_BITS + 1;
	localparam int SUM_BITS = HALF_BITS + 20;
	localparam int ACC_BITS = PT_BITS + 9;
	// weights are in 64ths on top of the 16 fraction bits
	localparam int SAMPLE_SHIFT = FRAC_BITS + 6;

	// a third and twice a third, 16 fraction bits
	localparam int W_THIRD_LO = 21845;
	localparam int W_THIRD_HI = 43691;

	localparam int NUM_SAMPLES = 5;
	localparam int T_BITS = $clog2(NUM_SAMPLES);
	localparam int W_BITS = 7;

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef logic [1:0] curve_idx_t;
	// curve between the older split point and the older control point
	localparam curve_idx_t CURVE_PREV = 2'd0;
	// curve between the older control point and the new midpoint
	localparam curve_idx_t CURVE_CUR = 2'd1;
	// closing curve of a run, ends on the final control point
	localparam curve_idx_t CURVE_LAST = 2'd2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [HALF_BITS-1:0] half_t;
	typedef half_t [2:0] half_vec_t;
	typedef logic signed [PT_BITS-1:0] pt_t;
	typedef logic signed [SUM_BITS-1:0] sum_t;
	typedef logic signed [ACC_BITS-1:0] acc_t;
	typedef logic [T_BITS-1:0] tidx_t;
	typedef logic [W_BITS-1:0] weight_t;

	typedef struct packed {
		coord_t x_in;
		coord_t y_in;
		coord_t z_in;
		logic   final_point;
	} pt_item_t;

	typedef struct packed {
		coord_t x_a;
		coord_t y_a;
		coord_t z_a;
		coord_t x_b;
		coord_t y_b;
		coord_t z_b;
		logic   run_end;
	} res_item_t;

	// work for one control point: its split points and the curves to draw
	typedef struct packed {
		half_vec_t  old_mid;
		half_vec_t  old_pt;
		half_vec_t  mid;
		half_vec_t  hp;
		curve_idx_t k_first;
		curve_idx_t k_last;
	} work_t;

	typedef struct packed {
		logic  valid;
		work_t work;
	} work_msg_t;

	// cubic Bernstein weights in 64ths, sample t, control point k
	function automatic weight_t bern_w(input tidx_t t, input logic [1:0] k);
		weight_t w [4];
		case (t)
			3'd0: w = '{7'd64, 7'd0, 7'd0, 7'd0};
			3'd1: w = '{7'd27, 7'd27, 7'd9, 7'd1};
			3'd2: w = '{7'd8, 7'd24, 7'd24, 7'd8};
			3'd3: w = '{7'd1, 7'd9, 7'd27, 7'd27};
			3'd4: w = '{7'd0, 7'd0, 7'd0, 7'd64};
			default: w = '{7'd0, 7'd0, 7'd0, 7'd0};
		endcase
		return w[k];
	endfunction

endpackage

// ===== design/polyline_bezier_tessellator.sv =====
`timescale 1ns / 1ps
// Polyline to cubic Bezier tessellator.
// Input channel pt_valid/pt_stall/pt_data carries one control point per
// transfer; final_point closes the run and returns all run state to reset.
// Output channel res_valid/res_stall/res_data carries one sample (point mode)
// or one line (line mode) per transfer; run_end marks the last result that a
// control point causes. cfg_we/cfg_wdata write draw_mode (0 point, 1 line);
// write it only while the block is idle.
// The first result of a control point passes the work queue, curve register,
// product stage and output register; line mode drops the first sample of a
// run. With work queued and no output stall the back end emits one sample
// per cycle, 5 per curve, so a control point yields 0 (first point of a
// run), 5, 10 or 15 samples of output (10 in the steady state).
// The front end takes a point every cycle while the work queue
// (QUEUE_DEPTH control points) has room, and raises pt_stall when it is full.
// A stalled result holds in the output register and freezes the sampler; the
// front end keeps filling the queue meanwhile.
// Reset clears the run state, queue and pipeline and sets point mode.
module polyline_bezier_tessellator #(
	parameter int QUEUE_DEPTH = pbt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pt_valid,
	output logic               pt_stall,
	input  pbt_pkg::pt_item_t  pt_data,
	output logic               res_valid,
	input  logic               res_stall,
	output pbt_pkg::res_item_t res_data,
	input  logic               cfg_we,
	input  logic               cfg_wdata
);
	import pbt_pkg::*;

	work_msg_t push;
	work_msg_t head;
	logic      q_full;
	logic      pop;
	logic      draw_mode_q;

	// mode register; hold it for the whole run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_mode_q <= 1'b0;
		end else if (cfg_we) begin
			draw_mode_q <= cfg_wdata;
		end
	end

	// front: accept points, track split points, queue curve work
	pbt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt_valid (pt_valid),
		.pt_stall (pt_stall),
		.pt_data  (pt_data),
		.q_full   (q_full),
		.push     (push)
	);

	// decouple the point rate from the sample rate
	pbt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	// back: build each curve, evaluate five samples, pair them into lines in line mode
	pbt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.draw_mode (draw_mode_q),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

// ===== design/pbt_queue.sv =====
`timescale 1ns / 1ps
`include "polyline_bezier_tessellator_defines.svh"
module pbt_queue #(
	parameter int DEPTH = pbt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pbt_pkg::work_msg_t push,
	output logic              full,
	output pbt_pkg::work_msg_t head,
	input  logic              pop
);
	import pbt_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	work_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full = cnt_q == CNT_W'(DEPTH);
	assign head.valid = cnt_q != '0;
	assign head.work = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push.valid) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.work;
		end
	end

	`PBT_ASSERT_ALWAYS(a_q_count_bound, cnt_q <= CNT_W'(DEPTH))
	`PBT_ASSERT_IMPLIES(a_q_pop_nonempty, pop, cnt_q != '0)
	`PBT_ASSERT_IMPLIES(a_q_push_has_room, push.valid, !full)

endmodule

// ===== design/pbt_front.sv =====
`timescale 1ns / 1ps
module pbt_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pt_valid,
	output logic               pt_stall,
	input  pbt_pkg::pt_item_t  pt_data,
	input  logic               q_full,
	output pbt_pkg::work_msg_t push
);
	import pbt_pkg::*;

	typedef enum logic [2:0] {
		SEEN_NONE = 3'b001,
		SEEN_ONE  = 3'b010,
		SEEN_MANY = 3'b100
	} seen_t;

	seen_t     seen_q;
	coord_t    last_q [3];
	half_vec_t mid_q;
	half_vec_t pt_q;

	coord_t    pc [3];
	half_vec_t hp;
	half_vec_t mid;
	logic      accept;

	assign pt_stall = q_full;
	assign accept = pt_valid && !pt_stall;

	always_comb begin
		pc[0] = pt_data.x_in;
		pc[1] = pt_data.y_in;
		pc[2] = pt_data.z_in;
		for (int c = 0; c < 3; c++) begin
			hp[c] = {pc[c], 1'b0};
			mid[c] = half_t'(last_q[c]) + half_t'(pc[c]);
		end
	end

	// classify: the first point of a run only primes the state
	always_comb begin
		push.valid = accept && (seen_q != SEEN_NONE);
		push.work.old_mid = mid_q;
		push.work.old_pt = pt_q;
		push.work.mid = mid;
		push.work.hp = hp;
		push.work.k_first = (seen_q == SEEN_MANY) ? CURVE_PREV : CURVE_CUR;
		push.work.k_last = pt_data.final_point ? CURVE_LAST : CURVE_CUR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= SEEN_NONE;
		end else if (accept) begin
			if (pt_data.final_point) begin
				seen_q <= SEEN_NONE;
			end else if (seen_q == SEEN_NONE) begin
				seen_q <= SEEN_ONE;
			end else begin
				seen_q <= SEEN_MANY;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_q <= pc;
			mid_q <= mid;
			pt_q <= hp;
		end
	end

endmodule

// ===== design/pbt_back.sv =====
`timescale 1ns / 1ps
`include "polyline_bezier_tessellator_defines.svh"
module pbt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  pbt_pkg::work_msg_t  head,
	output logic                pop,
	input  logic                draw_mode,
	output logic                res_valid,
	input  logic                res_stall,
	output pbt_pkg::res_item_t  res_data
);
	import pbt_pkg::*;

	// curve register and sample counter
	logic       cv_q;
	tidx_t      t_q;
	curve_idx_t k_q;
	logic       busy_q;
	pt_t        pts_s1 [3][4];
	logic       end_s1;
	logic       tail_s1;
	pt_t        prev_end_q [3];

	// product stage
	logic       v_s2;
	acc_t       prod_s2 [3][4];
	logic       end_s2;
	logic       clr_s2;

	// output register and line tracking
	logic       res_valid_q;
	res_item_t  res_q;
	coord_t     prev_q [3];
	logic       samp_valid_q;

	logic       adv;
	logic       t_last;
	logic       load;
	curve_idx_t cur_k;
	logic       is_last;
	logic       is_first;
	half_vec_t  ha;
	half_vec_t  hb;
	half_vec_t  hc;
	sum_t       sa [3];
	sum_t       sb [3];
	sum_t       sc [3];
	pt_t        np [3][4];

	acc_t       acc [3];
	acc_t       rnd [3];
	logic [ACC_BITS-COORD_BITS:0] top_b [3];
	coord_t     samp [3];
	logic       emit;

	assign adv = !(res_valid_q && res_stall);
	assign t_last = t_q == tidx_t'(NUM_SAMPLES - 1);
	assign load = head.valid && (!cv_q || (t_last && adv));
	assign cur_k = busy_q ? k_q : head.work.k_first;
	assign pop = load && (cur_k == head.work.k_last);
	assign is_last = cur_k == CURVE_LAST;
	assign is_first = (cur_k == CURVE_CUR) && (head.work.k_first == CURVE_CUR);

	// curve setup: pick the split points and place the four control points
	always_comb begin
		case (cur_k)
			CURVE_PREV: begin
				ha = head.work.old_mid;
				hb = head.work.old_pt;
				hc = head.work.mid;
			end
			CURVE_CUR: begin
				ha = head.work.old_pt;
				hb = head.work.mid;
				hc = head.work.hp;
			end
			default: begin
				ha = head.work.mid;
				hb = head.work.hp;
				hc = head.work.hp;
			end
		endcase
		for (int c = 0; c < 3; c++) begin
			sa[c] = sum_t'(ha[c]);
			sb[c] = sum_t'(hb[c]);
			sc[c] = sum_t'(hc[c]);
			np[c][0] = is_first ? pt_t'(sa[c] <<< (FRAC_BITS - 1)) : prev_end_q[c];
			np[c][1] = pt_t'((sum_t'(W_THIRD_HI) * sa[c] + sum_t'(W_THIRD_LO) * sb[c]
				+ sum_t'(1)) >>> 1);
			np[c][2] = pt_t'((sum_t'(W_THIRD_LO) * sa[c] + sum_t'(W_THIRD_HI) * sb[c]
				+ sum_t'(1)) >>> 1);
			np[c][3] = is_last ? pt_t'(sb[c] <<< (FRAC_BITS - 1))
				: pt_t'((sum_t'(W_THIRD_LO) * sa[c] + sum_t'(2 * W_THIRD_HI) * sb[c]
				+ sum_t'(W_THIRD_LO) * sc[c] + sum_t'(2)) >>> 2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q <= 1'b0;
			t_q <= '0;
			k_q <= CURVE_PREV;
			busy_q <= 1'b0;
		end else if (load) begin
			cv_q <= 1'b1;
			t_q <= '0;
			if (pop) begin
				busy_q <= 1'b0;
			end else begin
				busy_q <= 1'b1;
				k_q <= cur_k + 2'd1;
			end
		end else if (cv_q && adv) begin
			if (t_last) begin
				cv_q <= 1'b0;
			end else begin
				t_q <= t_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pts_s1 <= np;
			end_s1 <= pop;
			tail_s1 <= is_last;
			for (int c = 0; c < 3; c++) begin
				prev_end_q[c] <= np[c][3];
			end
		end
	end

	// weighted control points of one sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= cv_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cv_q) begin
			for (int c = 0; c < 3; c++) begin
				for (int k = 0; k < 4; k++) begin
					prod_s2[c][k] <= acc_t'(pts_s1[c][k]) * acc_t'(bern_w(t_q, 2'(k)));
				end
			end
			end_s2 <= end_s1 && t_last;
			clr_s2 <= tail_s1 && t_last;
		end
	end

	// sum, round to nearest, saturate
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			acc[c] = prod_s2[c][0] + prod_s2[c][1] + prod_s2[c][2] + prod_s2[c][3]
				+ (acc_t'(1) <<< (SAMPLE_SHIFT - 1));
			rnd[c] = acc[c] >>> SAMPLE_SHIFT;
			top_b[c] = rnd[c][ACC_BITS-1:COORD_BITS-1];
			if (&top_b[c] || ~|top_b[c]) begin
				samp[c] = rnd[c][COORD_BITS-1:0];
			end else if (rnd[c][ACC_BITS-1]) begin
				samp[c] = {1'b1, {(COORD_BITS - 1){1'b0}}};
			end else begin
				samp[c] = {1'b0, {(COORD_BITS - 1){1'b1}}};
			end
		end
	end

	// drop the first sample of a run in line mode
	assign emit = !draw_mode || samp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			samp_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= v_s2 && emit;
			if (v_s2) begin
				samp_valid_q <= !clr_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			res_q.x_a <= draw_mode ? prev_q[0] : samp[0];
			res_q.y_a <= draw_mode ? prev_q[1] : samp[1];
			res_q.z_a <= draw_mode ? prev_q[2] : samp[2];
			res_q.x_b <= draw_mode ? samp[0] : '0;
			res_q.y_b <= draw_mode ? samp[1] : '0;
			res_q.z_b <= draw_mode ? samp[2] : '0;
			res_q.run_end <= end_s2;
			prev_q <= samp;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data = res_q;

	`PBT_ASSERT_IMPLIES(a_b_t_range, cv_q, t_q <= tidx_t'(NUM_SAMPLES - 1))
	`PBT_ASSERT_IMPLIES(a_b_pop_head, pop, head.valid && load)
	`PBT_ASSERT_NEXT(a_b_hold_stalled, res_valid_q && res_stall, res_valid_q && $stable(res_q))

endmodule
